// ===== rtl/core/rgbl_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbl_pkg
// Shared types and constants of the RGB LED chain driver.
// ----------------------------------------------------------------------------
package rgbl_pkg;

  // opcodes carried in in_tuser
  localparam logic [2:0] OP_SET_PIXEL  = 3'd0;
  localparam logic [2:0] OP_GET_PIXEL  = 3'd1;
  localparam logic [2:0] OP_SET_BRIGHT = 3'd2;
  localparam logic [2:0] OP_CLEAR      = 3'd3;
  localparam logic [2:0] OP_SHOW       = 3'd4;
  localparam logic [2:0] OP_TICK       = 3'd5;

  // configuration register indexes
  localparam logic [2:0] CFG_RED_SLOT   = 3'd0;
  localparam logic [2:0] CFG_GREEN_SLOT = 3'd1;
  localparam logic [2:0] CFG_BLUE_SLOT  = 3'd2;
  localparam logic [2:0] CFG_BIT_PERIOD = 3'd3;
  localparam logic [2:0] CFG_ZERO_HIGH  = 3'd4;
  localparam logic [2:0] CFG_ONE_HIGH   = 3'd5;
  localparam logic [2:0] CFG_LATCH      = 3'd6;

  // serializer phases
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_DATA  = 2'd1;
  localparam logic [1:0] PH_LATCH = 2'd2;

  // a slot value that addresses no byte
  localparam logic [1:0] SLOT_NONE = 2'd3;

  localparam int DIV_NUM_W = 16;
  localparam int DIV_DEN_W = 8;

  // request to the shared divider
  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  // response of the shared divider
  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

// ===== rtl/core/rgbl_div.sv =====
// ----------------------------------------------------------------------------
// rgbl_div
// Restoring divider, one quotient bit per cycle, 16-bit by 8-bit unsigned.
// ----------------------------------------------------------------------------
module rgbl_div (
  input  logic               clk,
  input  logic               rst_n,
  input  rgbl_pkg::div_req_t req,
  output rgbl_pkg::div_rsp_t rsp
);

  logic                           active_r;
  logic                           done_r;
  logic [4:0]                     cnt_r;
  logic [rgbl_pkg::DIV_DEN_W-1:0] den_r;
  logic [rgbl_pkg::DIV_DEN_W-1:0] rem_r;
  logic [rgbl_pkg::DIV_NUM_W-1:0] quo_r;

  logic [rgbl_pkg::DIV_DEN_W:0]   rem_sh;
  logic                           ge;
  logic [rgbl_pkg::DIV_DEN_W-1:0] rem_nxt;
  logic [rgbl_pkg::DIV_NUM_W-1:0] quo_nxt;

  // one restoring step
  always_comb begin
    rem_sh  = {rem_r, quo_r[rgbl_pkg::DIV_NUM_W-1]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_nxt = ge ? 8'(rem_sh - {1'b0, den_r}) : rem_sh[rgbl_pkg::DIV_DEN_W-1:0];
    quo_nxt = {quo_r[rgbl_pkg::DIV_NUM_W-2:0], ge};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= 5'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !active_r) begin
        active_r <= 1'b1;
        cnt_r    <= 5'd0;
      end else if (active_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(rgbl_pkg::DIV_NUM_W - 1)) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start && !active_r) begin
      den_r <= req.den;
      rem_r <= '0;
      quo_r <= req.num;
    end else if (active_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign rsp.busy = active_r;
  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

// ===== rtl/core/rgb_led_chain_driver.sv =====
// ----------------------------------------------------------------------------
// rgb_led_chain_driver
// One-wire RGB LED chain driver: pixel store with brightness scaling,
// readback, store rescale and per-tick serial line generation.
// ----------------------------------------------------------------------------
// channel  direction  payload
// in_      slave      tdata: pixel_index[9:0] red[17:10] green[25:18] blue[33:26]
//                     tuser: opcode[2:0]
// out_     master     tdata: packed_color[23:0] brightness_level[31:24]
//                            line_level[32] busy_res[33]
// cfg_     write      cfg_addr = register index, cfg_wdata = value
//
// Per item: get pixel may run one divide per channel; set brightness to a new
// level rescales every store byte; clear writes every store byte. The
// single-port store and the shared multiplier/divider keep such items in the
// sequencer while in_tready is low.
// After reset a clearing pass over the whole store runs with in_tready low.
// rst_n is synchronous, active low. A finished result waits in the output
// register while the next item is accepted.
// ----------------------------------------------------------------------------
module rgb_led_chain_driver #(
  parameter int LED_COUNT = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // pixel_index, red, green, blue
  input  logic [2:0]  in_tuser,   // opcode
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // packed_color, brightness_level, line_level, busy_res
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  localparam int STORE_BYTES = LED_COUNT * 3;
  localparam int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam logic [AW-1:0]  LAST_ADDR = AW'(STORE_BYTES - 1);
  localparam logic [10:0]    LED_CNT_W = 11'(LED_COUNT);

  // sequencer states
  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_SETW = 4'd2;
  localparam logic [3:0] S_GRD  = 4'd3;
  localparam logic [3:0] S_GDAT = 4'd4;
  localparam logic [3:0] S_GDIV = 4'd5;
  localparam logic [3:0] S_BCHK = 4'd6;
  localparam logic [3:0] S_BDIV = 4'd7;
  localparam logic [3:0] S_BRD  = 4'd8;
  localparam logic [3:0] S_BWR  = 4'd9;
  localparam logic [3:0] S_TRD  = 4'd10;
  localparam logic [3:0] S_TEX  = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;

  // configuration registers
  logic [1:0]  red_slot_r, green_slot_r, blue_slot_r;
  logic [7:0]  bit_period_r, zero_high_r, one_high_r;
  logic [15:0] latch_ticks_r;

  // sequencer and item registers
  logic [3:0]    st_r;
  logic [2:0]    op_r;
  logic          idx_ok_r;
  logic [AW-1:0] base_r;
  logic [7:0]    red_r, green_r, blue_r;
  logic [1:0]    ch_r;
  logic [AW-1:0] addr_r;
  logic [15:0]   scale_r;
  logic [7:0]    nb_r;
  logic [23:0]   pack_r;
  logic          line_r;
  logic          busy_r;
  logic          clr_op_r;
  logic [7:0]    bright_r;

  // serializer state
  logic [1:0]    phase_r;
  logic [AW-1:0] byte_ptr_r;
  logic [2:0]    bit_ptr_r;
  logic [15:0]   tc_r;

  // output register
  logic        out_valid_r;
  logic [39:0] out_data_r;

  // pixel store
  logic [7:0]    mem [STORE_BYTES];
  logic [7:0]    rd_data_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;

  // shared divider
  rgbl_pkg::div_req_t div_req;
  rgbl_pkg::div_rsp_t div_rsp;

  // input fields
  logic [9:0] in_idx;
  logic [7:0] in_red, in_green, in_blue;
  logic       in_acc;
  logic [11:0] in_base;

  // channel selection and shared multiplier
  logic [1:0]  slot_sel;
  logic [7:0]  comp_sel;
  logic [AW-1:0] chan_addr;
  logic [7:0]  mul_a;
  logic [15:0] mul_b;
  logic [23:0] mul_p;
  logic [7:0]  unscaled;
  logic [7:0]  chan_val;
  logic [7:0]  nb_calc;
  logic [7:0]  old_calc;

  // tick datapath
  logic        tk_bit;
  logic [7:0]  tk_high;
  logic [16:0] tc_inc;

  assign in_idx   = in_tdata[9:0];
  assign in_red   = in_tdata[17:10];
  assign in_green = in_tdata[25:18];
  assign in_blue  = in_tdata[33:26];
  assign in_tready = (st_r == S_IDLE);
  assign in_acc   = in_tvalid && in_tready;
  assign in_base  = {2'b00, in_idx} + {1'b0, in_idx, 1'b0};

  // channel in progress
  always_comb begin
    case (ch_r)
      2'd0:    begin slot_sel = red_slot_r;   comp_sel = red_r;   end
      2'd1:    begin slot_sel = green_slot_r; comp_sel = green_r; end
      default: begin slot_sel = blue_slot_r;  comp_sel = blue_r;  end
    endcase
    chan_addr = base_r + AW'(slot_sel);
  end

  // shared 8x16 multiplier: colour by brightness, or store byte by rescale
  always_comb begin
    if (st_r == S_BWR) begin
      mul_a = rd_data_r;
      mul_b = scale_r;
    end else begin
      mul_a = comp_sel;
      mul_b = {8'd0, bright_r};
    end
    mul_p = {16'd0, mul_a} * {8'd0, mul_b};
  end

  assign unscaled = (|div_rsp.quo[15:8]) ? 8'hFF : div_rsp.quo[7:0];
  assign chan_val = (st_r == S_GDIV) ? unscaled :
                    (slot_sel == rgbl_pkg::SLOT_NONE) ? 8'd0 : rd_data_r;
  assign nb_calc  = blue_r + 8'd1;
  assign old_calc = bright_r - 8'd1;

  // divider requests: readback unscale or rescale factor
  always_comb begin
    div_req = '0;
    if (st_r == S_GDAT && slot_sel != rgbl_pkg::SLOT_NONE && bright_r != 8'd0) begin
      div_req.start = 1'b1;
      div_req.num   = {rd_data_r, 8'd0};
      div_req.den   = bright_r;
    end else if (st_r == S_BCHK && nb_calc != bright_r && old_calc != 8'd0) begin
      div_req.start = 1'b1;
      div_req.num   = (blue_r == 8'hFF) ? 16'hFFFF : 16'({nb_calc, 8'd0} - 16'd1);
      div_req.den   = old_calc;
    end
  end

  rgbl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // store port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = 8'd0;
    mem_raddr = addr_r;
    unique case (st_r)
      S_CLR: mem_we = 1'b1;
      S_SETW: begin
        mem_we    = idx_ok_r && (slot_sel != rgbl_pkg::SLOT_NONE);
        mem_waddr = chan_addr;
        mem_wdata = (bright_r != 8'd0) ? mul_p[15:8] : comp_sel;
      end
      S_BWR: begin
        mem_we    = 1'b1;
        mem_wdata = mul_p[15:8];
      end
      S_GRD:   mem_raddr = chan_addr;
      S_TRD:   mem_raddr = byte_ptr_r;
      default: mem_raddr = addr_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_slot_r    <= 2'd1;
      green_slot_r  <= 2'd0;
      blue_slot_r   <= 2'd2;
      bit_period_r  <= 8'd20;
      zero_high_r   <= 8'd6;
      one_high_r    <= 8'd13;
      latch_ticks_r <= 16'd40;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        rgbl_pkg::CFG_RED_SLOT:   red_slot_r    <= cfg_wdata[1:0];
        rgbl_pkg::CFG_GREEN_SLOT: green_slot_r  <= cfg_wdata[1:0];
        rgbl_pkg::CFG_BLUE_SLOT:  blue_slot_r   <= cfg_wdata[1:0];
        rgbl_pkg::CFG_BIT_PERIOD: bit_period_r  <= cfg_wdata[7:0];
        rgbl_pkg::CFG_ZERO_HIGH:  zero_high_r   <= cfg_wdata[7:0];
        rgbl_pkg::CFG_ONE_HIGH:   one_high_r    <= cfg_wdata[7:0];
        rgbl_pkg::CFG_LATCH:      latch_ticks_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // tick datapath
  assign tk_bit  = rd_data_r[~bit_ptr_r];
  assign tk_high = tk_bit ? one_high_r : zero_high_r;
  assign tc_inc  = {1'b0, tc_r} + 17'd1;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLR;
      addr_r      <= '0;
      clr_op_r    <= 1'b0;
      bright_r    <= 8'd0;
      phase_r     <= rgbl_pkg::PH_IDLE;
      byte_ptr_r  <= '0;
      bit_ptr_r   <= 3'd0;
      tc_r        <= 16'd0;
      out_valid_r <= 1'b0;
      ch_r        <= 2'd0;
    end else begin
      // output register: load a finished result or drop a taken one
      if (st_r == S_DONE && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        S_CLR: begin
          if (addr_r == LAST_ADDR) begin
            addr_r <= '0;
            st_r   <= clr_op_r ? S_DONE : S_IDLE;
          end else begin
            addr_r <= addr_r + AW'(1);
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            op_r     <= in_tuser;
            idx_ok_r <= {1'b0, in_idx} < LED_CNT_W;
            base_r   <= in_base[AW-1:0];
            red_r    <= in_red;
            green_r  <= in_green;
            blue_r   <= in_blue;
            ch_r     <= 2'd0;
            addr_r   <= '0;
            pack_r   <= 24'd0;
            line_r   <= 1'b0;
            busy_r   <= phase_r != rgbl_pkg::PH_IDLE;
            clr_op_r <= (in_tuser == rgbl_pkg::OP_CLEAR);
            unique case (in_tuser)
              rgbl_pkg::OP_SET_PIXEL:  st_r <= S_SETW;
              rgbl_pkg::OP_GET_PIXEL:
                st_r <= ({1'b0, in_idx} < LED_CNT_W) ? S_GRD : S_DONE;
              rgbl_pkg::OP_SET_BRIGHT: st_r <= S_BCHK;
              rgbl_pkg::OP_CLEAR:      st_r <= S_CLR;
              rgbl_pkg::OP_SHOW: begin
                if (phase_r == rgbl_pkg::PH_IDLE) begin
                  phase_r    <= rgbl_pkg::PH_DATA;
                  byte_ptr_r <= '0;
                  bit_ptr_r  <= 3'd0;
                  tc_r       <= 16'd0;
                end
                st_r <= S_DONE;
              end
              rgbl_pkg::OP_TICK: st_r <= S_TRD;
              default:           st_r <= S_DONE;
            endcase
          end
        end
        S_SETW: begin
          ch_r <= ch_r + 2'd1;
          if (ch_r == 2'd2) begin
            st_r <= S_DONE;
          end
        end
        S_GRD: st_r <= S_GDAT;
        S_GDAT: begin
          if (div_req.start) begin
            st_r <= S_GDIV;
          end else begin
            pack_r <= {pack_r[15:0], chan_val};
            ch_r   <= ch_r + 2'd1;
            st_r   <= (ch_r == 2'd2) ? S_DONE : S_GRD;
          end
        end
        S_GDIV: begin
          if (div_rsp.done) begin
            pack_r <= {pack_r[15:0], chan_val};
            ch_r   <= ch_r + 2'd1;
            st_r   <= (ch_r == 2'd2) ? S_DONE : S_GRD;
          end
        end
        S_BCHK: begin
          nb_r    <= nb_calc;
          scale_r <= 16'd0;
          if (nb_calc == bright_r) begin
            st_r <= S_DONE;
          end else if (div_req.start) begin
            st_r <= S_BDIV;
          end else begin
            st_r <= S_BRD;
          end
        end
        S_BDIV: begin
          if (div_rsp.done) begin
            scale_r <= div_rsp.quo;
            st_r    <= S_BRD;
          end
        end
        S_BRD: st_r <= S_BWR;
        S_BWR: begin
          if (addr_r == LAST_ADDR) begin
            addr_r   <= '0;
            bright_r <= nb_r;
            st_r     <= S_DONE;
          end else begin
            addr_r <= addr_r + AW'(1);
            st_r   <= S_BRD;
          end
        end
        S_TRD: st_r <= S_TEX;
        S_TEX: begin
          st_r <= S_DONE;
          if (phase_r == rgbl_pkg::PH_DATA) begin
            line_r <= {8'd0, tk_high} > tc_r;
            if (tc_inc >= {9'd0, bit_period_r}) begin
              tc_r      <= 16'd0;
              bit_ptr_r <= bit_ptr_r + 3'd1;
              if (bit_ptr_r == 3'd7) begin
                if (byte_ptr_r == LAST_ADDR) begin
                  byte_ptr_r <= '0;
                  phase_r    <= rgbl_pkg::PH_LATCH;
                end else begin
                  byte_ptr_r <= byte_ptr_r + AW'(1);
                end
              end
            end else begin
              tc_r <= tc_inc[15:0];
            end
          end else if (phase_r == rgbl_pkg::PH_LATCH) begin
            if (tc_inc >= {1'b0, latch_ticks_r}) begin
              tc_r    <= 16'd0;
              phase_r <= rgbl_pkg::PH_IDLE;
            end else begin
              tc_r <= tc_inc[15:0];
            end
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_data_r  <= {6'd0,
                            (op_r == rgbl_pkg::OP_TICK) ? busy_r
                                                        : (phase_r != rgbl_pkg::PH_IDLE),
                            line_r, old_calc, pack_r};
            st_r        <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // an accepted item always takes the sequencer out of idle
  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("sequencer stayed idle after accepting an item");

  // the divider only finishes while the sequencer waits for it
  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (st_r == S_GDIV || st_r == S_BDIV))
    else $error("divider result with no waiting state");

  // an idle serializer always has a zero tick count
  a_idle_tc: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == rgbl_pkg::PH_IDLE) |-> (tc_r == 16'd0))
    else $error("tick count nonzero while line idle");

  // a finished result waits while the output register is still full and not taken
  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DONE && out_valid_r && !out_tready) |=> (st_r == S_DONE))
    else $error("result dropped while output stalled");

endmodule

// ===== tb/sv/rgb_led_chain_driver_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_led_chain_driver_tb
// Self-checking bench for the LED chain driver. A queue of items feeds a
// stream driver; each accepted item runs through a local model of the pixel
// store, brightness and serializer, and the monitor compares every result
// field with the oldest prediction. Configuration changes happen between
// phases while the block is idle.
// ----------------------------------------------------------------------------
module rgb_led_chain_driver_tb;

  localparam int LEDS      = 64;
  localparam int BYTES     = LEDS * 3;
  localparam int STALL_MAX = 20000;

  typedef struct packed {
    logic [2:0] op;
    logic [9:0] idx;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } led_item_t;

  typedef struct packed {
    logic [23:0] color;
    logic [7:0]  level;
    logic        line;
    logic        busy;
  } led_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [15:0] cfg_wdata;

  rgb_led_chain_driver #(.LED_COUNT(LEDS)) u_dut (.*);

  // model state
  logic [1:0]  m_slot [3];
  logic [7:0]  m_period, m_zero_hi, m_one_hi;
  logic [15:0] m_latch;
  logic [7:0]  m_store [BYTES];
  logic [7:0]  m_bright;
  int          m_byte, m_bit, m_ticks;
  logic [1:0]  m_phase;

  led_item_t   pending_items[$];
  led_result_t expected_results[$];
  int          mismatches;
  bit          no_idle;
  int          in_gap, out_gap;
  int          quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] scale_in(logic [7:0] c);
    if (m_bright == 0) return c;
    return 8'((int'(c) * int'(m_bright)) >> 8);
  endfunction

  function automatic int unscale(int v);
    int q;
    if (m_bright == 0) return v;
    q = (v << 8) / int'(m_bright);
    return (q > 255) ? 255 : q;
  endfunction

  function automatic int read_slot(int base, logic [1:0] s);
    return (s == rgbl_pkg::SLOT_NONE) ? 0 : int'(m_store[base + s]);
  endfunction

  // brightness change rescales the whole store
  function automatic void rescale(logic [7:0] lvl);
    logic [7:0] nb, old;
    int scale;
    nb = lvl + 8'd1;
    if (nb == m_bright) return;
    old = m_bright - 8'd1;
    if (old == 0) scale = 0;
    else if (lvl == 8'd255) scale = 65535 / int'(old);
    else scale = ((((int'(nb) << 8) - 1) / int'(old)) & 16'hFFFF);
    for (int i = 0; i < BYTES; i++)
      m_store[i] = 8'((int'(m_store[i]) * scale) >> 8);
    m_bright = nb;
  endfunction

  function automatic logic serial_tick();
    logic ln, bitv;
    int hi;
    ln = 1'b0;
    if (m_phase == rgbl_pkg::PH_DATA) begin
      bitv = m_store[m_byte][7 - m_bit];
      hi = bitv ? m_one_hi : m_zero_hi;
      ln = m_ticks < hi;
      m_ticks++;
      if (m_ticks >= m_period) begin
        m_ticks = 0;
        if (m_bit >= 7) begin
          m_bit = 0;
          m_byte++;
          if (m_byte >= BYTES) begin
            m_byte = 0;
            m_phase = rgbl_pkg::PH_LATCH;
          end
        end else begin
          m_bit++;
        end
      end
    end else if (m_phase == rgbl_pkg::PH_LATCH) begin
      m_ticks++;
      if (m_ticks >= m_latch) begin
        m_ticks = 0;
        m_phase = rgbl_pkg::PH_IDLE;
      end
    end
    return ln;
  endfunction

  function automatic led_result_t predict_led(led_item_t it);
    led_result_t res;
    int base;
    res = '0;
    base = int'(it.idx) * 3;
    res.busy = m_phase != rgbl_pkg::PH_IDLE;
    case (it.op)
      rgbl_pkg::OP_SET_PIXEL: if (it.idx < LEDS) begin
        if (m_slot[0] != rgbl_pkg::SLOT_NONE) m_store[base + m_slot[0]] = scale_in(it.r);
        if (m_slot[1] != rgbl_pkg::SLOT_NONE) m_store[base + m_slot[1]] = scale_in(it.g);
        if (m_slot[2] != rgbl_pkg::SLOT_NONE) m_store[base + m_slot[2]] = scale_in(it.b);
      end
      rgbl_pkg::OP_GET_PIXEL: if (it.idx < LEDS) begin
        res.color = {8'(unscale(read_slot(base, m_slot[0]))),
                     8'(unscale(read_slot(base, m_slot[1]))),
                     8'(unscale(read_slot(base, m_slot[2])))};
      end
      rgbl_pkg::OP_SET_BRIGHT: rescale(it.b);
      rgbl_pkg::OP_CLEAR: for (int i = 0; i < BYTES; i++) m_store[i] = 8'd0;
      rgbl_pkg::OP_SHOW: if (m_phase == rgbl_pkg::PH_IDLE) begin
        m_phase = rgbl_pkg::PH_DATA;
        m_byte = 0;
        m_bit = 0;
        m_ticks = 0;
      end
      rgbl_pkg::OP_TICK: res.line = serial_tick();
      default: ;
    endcase
    if (it.op != rgbl_pkg::OP_TICK) res.busy = m_phase != rgbl_pkg::PH_IDLE;
    res.level = m_bright - 8'd1;
    return res;
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid)
        expected_results.push_back(predict_led({in_tuser, in_tdata[9:0], in_tdata[17:10],
                                                in_tdata[25:18], in_tdata[33:26]}));
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_items.size() > 0 && (no_idle || $urandom_range(7) != 0)) begin
        led_item_t it;
        it = pending_items.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= it.op;
        in_tdata <= {6'd0, it.b, it.g, it.r, it.idx};
      end else begin
        in_tvalid <= 1'b0;
        if (!no_idle && pending_items.size() > 0) in_gap <= $urandom_range(2);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("result with no prediction: %h", out_tdata);
          mismatches++;
        end else begin
          led_result_t e;
          e = expected_results.pop_front();
          if (out_tdata[23:0] !== e.color) begin
            $error("packed_color exp %h got %h", e.color, out_tdata[23:0]);
            mismatches++;
          end
          if (out_tdata[31:24] !== e.level) begin
            $error("brightness_level exp %h got %h", e.level, out_tdata[31:24]);
            mismatches++;
          end
          if (out_tdata[32] !== e.line) begin
            $error("line_level exp %b got %b", e.line, out_tdata[32]);
            mismatches++;
          end
          if (out_tdata[33] !== e.busy) begin
            $error("busy_res exp %b got %b", e.busy, out_tdata[33]);
            mismatches++;
          end
        end
      end
      if (no_idle) begin
        out_tready <= 1'b1;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_tready <= 1'b0;
      end else if ($urandom_range(7) == 0) begin
        out_gap <= $urandom_range(2);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_MAX) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic push_item(logic [2:0] op, logic [9:0] idx, logic [7:0] r,
                           logic [7:0] g, logic [7:0] b);
    pending_items.push_back({op, idx, r, g, b});
  endtask

  // wait until all items are accepted and all results are back
  task automatic drain();
    while (pending_items.size() > 0 || in_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (3 * LEDS + 100) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (addr)
      rgbl_pkg::CFG_RED_SLOT:   m_slot[0] = val[1:0];
      rgbl_pkg::CFG_GREEN_SLOT: m_slot[1] = val[1:0];
      rgbl_pkg::CFG_BLUE_SLOT:  m_slot[2] = val[1:0];
      rgbl_pkg::CFG_BIT_PERIOD: m_period = val[7:0];
      rgbl_pkg::CFG_ZERO_HIGH:  m_zero_hi = val[7:0];
      rgbl_pkg::CFG_ONE_HIGH:   m_one_hi = val[7:0];
      rgbl_pkg::CFG_LATCH:      m_latch = val;
      default: ;
    endcase
  endtask

  // random item, weighted toward pixel work and ticks
  task automatic push_random();
    int k;
    logic [9:0] idx;
    logic [7:0] r, g, b;
    k = $urandom_range(99);
    idx = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(LEDS - 1));
    r = 8'($urandom);
    g = 8'($urandom);
    b = 8'($urandom);
    if (k < 25)      push_item(rgbl_pkg::OP_SET_PIXEL, idx, r, g, b);
    else if (k < 40) push_item(rgbl_pkg::OP_GET_PIXEL, idx, r, g, b);
    else if (k < 43) push_item(rgbl_pkg::OP_SET_BRIGHT, idx, r, g, b);
    else if (k < 44) push_item(rgbl_pkg::OP_CLEAR, idx, r, g, b);
    else if (k < 48) push_item(rgbl_pkg::OP_SHOW, idx, r, g, b);
    else if (k < 97) push_item(rgbl_pkg::OP_TICK, idx, r, g, b);
    else             push_item(3'($urandom_range(6, 7)), idx, r, g, b);
  endtask

  initial begin
    mismatches = 0;
    no_idle = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    quiet_cycles = 0;
    m_slot[0] = 2'd1; m_slot[1] = 2'd0; m_slot[2] = 2'd2;
    m_period = 8'd20; m_zero_hi = 8'd6; m_one_hi = 8'd13; m_latch = 16'd40;
    foreach (m_store[i]) m_store[i] = 8'd0;
    m_bright = 8'd0;
    m_byte = 0; m_bit = 0; m_ticks = 0;
    m_phase = rgbl_pkg::PH_IDLE;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, every opcode, out-of-range index, unused codes
    push_item(rgbl_pkg::OP_SET_PIXEL, 10'd0, 8'hFF, 8'h00, 8'hA5);
    push_item(rgbl_pkg::OP_SET_PIXEL, 10'd63, 8'h80, 8'h7F, 8'h01);
    push_item(rgbl_pkg::OP_SET_PIXEL, 10'd1023, 8'hFF, 8'hFF, 8'hFF);
    push_item(rgbl_pkg::OP_GET_PIXEL, 10'd0, 8'h00, 8'h00, 8'h00);
    push_item(rgbl_pkg::OP_GET_PIXEL, 10'd63, 8'h00, 8'h00, 8'h00);
    push_item(rgbl_pkg::OP_GET_PIXEL, 10'd64, 8'h00, 8'h00, 8'h00);
    push_item(rgbl_pkg::OP_TICK, 10'd0, 8'h00, 8'h00, 8'h00);
    push_item(rgbl_pkg::OP_SET_BRIGHT, 10'd0, 8'h00, 8'h00, 8'd127);
    push_item(rgbl_pkg::OP_SET_PIXEL, 10'd5, 8'hFF, 8'h55, 8'hAA);
    push_item(rgbl_pkg::OP_GET_PIXEL, 10'd5, 8'h00, 8'h00, 8'h00);
    push_item(rgbl_pkg::OP_SET_BRIGHT, 10'd0, 8'h00, 8'h00, 8'd255);
    push_item(rgbl_pkg::OP_GET_PIXEL, 10'd0, 8'h00, 8'h00, 8'h00);
    push_item(rgbl_pkg::OP_SET_BRIGHT, 10'd0, 8'h00, 8'h00, 8'd255);
    push_item(rgbl_pkg::OP_SET_BRIGHT, 10'd0, 8'h00, 8'h00, 8'd0);
    push_item(rgbl_pkg::OP_SET_BRIGHT, 10'd0, 8'h00, 8'h00, 8'd64);
    push_item(rgbl_pkg::OP_SHOW, 10'd0, 8'h00, 8'h00, 8'h00);
    push_item(rgbl_pkg::OP_SHOW, 10'd0, 8'h00, 8'h00, 8'h00);
    repeat (4) push_item(rgbl_pkg::OP_TICK, 10'h3FF, 8'hFF, 8'hFF, 8'hFF);
    push_item(3'd6, 10'd1, 8'h00, 8'h00, 8'h00);
    push_item(3'd7, 10'd2, 8'h00, 8'h00, 8'h00);
    push_item(rgbl_pkg::OP_CLEAR, 10'd0, 8'h00, 8'h00, 8'h00);
    push_item(rgbl_pkg::OP_GET_PIXEL, 10'd63, 8'h00, 8'h00, 8'h00);
    drain();

    // phases with different settings, short bit timing in all but the last
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(rgbl_pkg::CFG_RED_SLOT, 16'd0); write_reg(rgbl_pkg::CFG_GREEN_SLOT, 16'd1);
          write_reg(rgbl_pkg::CFG_BLUE_SLOT, 16'd2); write_reg(rgbl_pkg::CFG_BIT_PERIOD, 16'd2);
          write_reg(rgbl_pkg::CFG_ZERO_HIGH, 16'd1); write_reg(rgbl_pkg::CFG_ONE_HIGH, 16'd1);
          write_reg(rgbl_pkg::CFG_LATCH, 16'd1);
        end
        1: begin
          write_reg(rgbl_pkg::CFG_RED_SLOT, 16'd3); write_reg(rgbl_pkg::CFG_GREEN_SLOT, 16'd2);
          write_reg(rgbl_pkg::CFG_BLUE_SLOT, 16'd2); write_reg(rgbl_pkg::CFG_ONE_HIGH, 16'd254);
          write_reg(rgbl_pkg::CFG_LATCH, 16'd3);
        end
        2: begin
          write_reg(rgbl_pkg::CFG_RED_SLOT, 16'd2); write_reg(rgbl_pkg::CFG_GREEN_SLOT, 16'd3);
          write_reg(rgbl_pkg::CFG_BLUE_SLOT, 16'd0); write_reg(rgbl_pkg::CFG_BIT_PERIOD, 16'd0);
          write_reg(rgbl_pkg::CFG_ZERO_HIGH, 16'd254); write_reg(rgbl_pkg::CFG_LATCH, 16'd0);
        end
        3: begin
          write_reg(rgbl_pkg::CFG_BLUE_SLOT, 16'd3); write_reg(rgbl_pkg::CFG_BIT_PERIOD, 16'd1);
          write_reg(rgbl_pkg::CFG_ZERO_HIGH, 16'd0); write_reg(rgbl_pkg::CFG_ONE_HIGH, 16'd1);
        end
        4: begin
          write_reg(rgbl_pkg::CFG_RED_SLOT, 16'd1); write_reg(rgbl_pkg::CFG_GREEN_SLOT, 16'd0);
          write_reg(rgbl_pkg::CFG_BLUE_SLOT, 16'd2); write_reg(rgbl_pkg::CFG_BIT_PERIOD, 16'd3);
          write_reg(rgbl_pkg::CFG_ZERO_HIGH, 16'd1); write_reg(rgbl_pkg::CFG_ONE_HIGH, 16'd2);
          write_reg(rgbl_pkg::CFG_LATCH, 16'd2);
        end
        default: begin
          // long timing; the frame is still in progress at the end
          write_reg(rgbl_pkg::CFG_BIT_PERIOD, 16'd255);
          write_reg(rgbl_pkg::CFG_ZERO_HIGH, 16'd6);
          write_reg(rgbl_pkg::CFG_ONE_HIGH, 16'd200);
          write_reg(rgbl_pkg::CFG_LATCH, 16'd65535);
          no_idle = 1'b1;
        end
      endcase
      repeat (300) push_random();
      // hold off until every result is back, once per phase
      while (pending_items.size() > 0 || in_tvalid || expected_results.size() > 0)
        @(posedge clk);
      drain();
    end

    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
